### rtl/core/plsg_pkg.sv
// ----------------------------------------------------------------------------
// plsg_pkg
// Shared types, codes and constants of the parallel LCG stream generator.
// ----------------------------------------------------------------------------
package plsg_pkg;

    localparam int unsigned SEQ_BITS_MAX_DEF = 24;

    localparam int unsigned SEED_W       = 64;
    localparam int unsigned HALF_W       = 32;
    localparam int unsigned FRAC_W       = 52;
    localparam int unsigned FRAC_LSB     = SEED_W - FRAC_W;
    localparam int unsigned SEQ_ID_W     = 24;
    localparam int unsigned BITS_W       = 7;
    localparam int unsigned PID_W        = 16;
    localparam int unsigned OP_W         = 2;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned CFG_IDX_W    = 3;

    localparam logic [BITS_W-1:0]  MIN_RUN_BITS = 7'd24;
    localparam logic [SEED_W-1:0]  LCG_MULT     = 64'h5851_F42D_4C95_7F2D;
    localparam logic [HALF_W-1:0]  LCG_MULT_LO  = LCG_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0]  LCG_MULT_HI  = LCG_MULT[SEED_W-1:HALF_W];

    // Seed layout modes
    localparam logic [MODE_W-1:0] MODE_PART_LOW = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEQ_LOW  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GSEED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PART_ID   = 3'd5;

    // Configuration reset values
    localparam logic [MODE_W-1:0] RST_MODE      = MODE_PART_LOW;
    localparam logic [BITS_W-1:0] RST_RUN_BITS  = 7'd24;
    localparam logic [BITS_W-1:0] RST_PART_BITS = 7'd0;
    localparam logic [BITS_W-1:0] RST_SEQ_BITS  = 7'd8;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 2'd0,
        OP_NEW_SEQ = 2'd1,
        OP_DRAW    = 2'd2,
        OP_LOAD    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_REINIT    = 3'd1,
        ST_BAD_MODE  = 3'd2,
        ST_RUN_SHORT = 3'd3,
        ST_SEQ_WIDE  = 3'd4,
        ST_SUM_WIDE  = 3'd5,
        ST_EXHAUSTED = 3'd6,
        ST_UNINIT    = 3'd7
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BITS_W-1:0] run_bits;
        logic [BITS_W-1:0] part_bits;
        logic [BITS_W-1:0] seq_bits;
        logic [SEED_W-1:0] global_seed;
        logic [PID_W-1:0]  partition_id;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [SEED_W-1:0] seed_value;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [SEED_W-1:0]   seed_out;
        logic [SEQ_ID_W-1:0] sequence_id;
        logic [FRAC_W-1:0]   random_fraction;
    } t_result;

endpackage

### rtl/core/plsg_if.sv
// ----------------------------------------------------------------------------
// plsg channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface plsg_in_if;
    import plsg_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed_value;
    modport source (output valid, op, seed_value, input ready);
    modport sink   (input valid, op, seed_value, output ready);
endinterface

interface plsg_out_if;
    import plsg_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEED_W-1:0]   seed_out;
    logic [SEQ_ID_W-1:0] sequence_id;
    logic [FRAC_W-1:0]   random_fraction;
    modport source (output valid, status, seed_out, sequence_id, random_fraction,
                    input ready);
    modport sink   (input valid, status, seed_out, sequence_id, random_fraction,
                    output ready);
endinterface

interface plsg_cfg_if;
    import plsg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SEED_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/plsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// plsg_cfg_regs
// Configuration register file: mode, field sizes, global seed, partition id.
// ----------------------------------------------------------------------------
module plsg_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [plsg_pkg::CFG_IDX_W-1:0] i_wr_idx,
    input  logic [plsg_pkg::SEED_W-1:0]    i_wr_data,
    output plsg_pkg::t_cfg                 o_cfg
);
    import plsg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_idx)
                CFG_MODE:      n_cfg.mode         = i_wr_data[MODE_W-1:0];
                CFG_RUN_BITS:  n_cfg.run_bits     = i_wr_data[BITS_W-1:0];
                CFG_PART_BITS: n_cfg.part_bits    = i_wr_data[BITS_W-1:0];
                CFG_SEQ_BITS:  n_cfg.seq_bits     = i_wr_data[BITS_W-1:0];
                CFG_GSEED:     n_cfg.global_seed  = i_wr_data;
                CFG_PART_ID:   n_cfg.partition_id = i_wr_data[PID_W-1:0];
                default:       n_cfg = r_cfg;  // unknown index: drop the write
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= RST_MODE;
            r_cfg.run_bits     <= RST_RUN_BITS;
            r_cfg.part_bits    <= RST_PART_BITS;
            r_cfg.seq_bits     <= RST_SEQ_BITS;
            r_cfg.global_seed  <= '0;
            r_cfg.partition_id <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/plsg_in_reg.sv
// ----------------------------------------------------------------------------
// plsg_in_reg
// Input register: holds one accepted word until the step unit takes it.
// ----------------------------------------------------------------------------
module plsg_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  plsg_pkg::t_item i_item,
    output logic            o_ready,
    input  logic            i_advance,
    output logic            o_valid,
    output plsg_pkg::t_item o_item
);
    import plsg_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // Free when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/plsg_lcg_unit.sv
// ----------------------------------------------------------------------------
// plsg_lcg_unit
// Generator state and the single-pass step: init, new sequence, draw, load.
// ----------------------------------------------------------------------------
module plsg_lcg_unit #(
    parameter int unsigned SEQ_BITS_MAX = plsg_pkg::SEQ_BITS_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plsg_pkg::t_cfg    i_cfg,
    input  logic              i_advance,
    input  plsg_pkg::t_item   i_item,
    output plsg_pkg::t_result o_result
);
    import plsg_pkg::*;

    localparam int unsigned CW = SEQ_BITS_MAX;

    logic [SEED_W-1:0] r_cur_seed, n_cur_seed;
    logic [SEED_W-1:0] r_base_seed, n_base_seed;
    logic [CW-1:0]     r_seq_cnt, n_seq_cnt;
    logic [CW-1:0]     r_seq_mask, n_seq_mask;
    logic [BITS_W-1:0] r_seq_shift, n_seq_shift;
    logic              r_init, n_init;

    logic [BITS_W+1:0] bits_sum;
    logic [BITS_W:0]   pid_pos;
    logic [BITS_W:0]   seq_pos;
    logic [SEED_W-1:0] pid_masked;
    logic [SEED_W-1:0] init_base;
    logic [CW:0]       mask_one;
    logic [CW-1:0]     init_mask;
    logic [CW-1:0]     seq_next;
    logic [HALF_W-1:0] seed_lo, seed_hi;
    logic [SEED_W-1:0] prod_ll;
    logic [HALF_W-1:0] prod_lh, prod_hl;
    logic [SEED_W-1:0] draw_seed;
    t_status           status;
    logic [FRAC_W-1:0] frac;

    function automatic logic [SEED_W-1:0] low_mask64(input logic [BITS_W-1:0] bits);
        logic [SEED_W-1:0] m;
        m = (64'd1 << bits[5:0]) - 64'd1;
        if (bits >= 7'd64) begin
            m = '1;
        end
        return m;
    endfunction

    function automatic logic [SEED_W-1:0] shl64(input logic [SEED_W-1:0] v,
                                                input logic [BITS_W:0]   s);
        logic [SEED_W-1:0] r;
        r = v << s[5:0];
        if (s >= 8'd64) begin
            r = '0;
        end
        return r;
    endfunction

    // Init: seed layout from the field sizes
    assign bits_sum   = {2'b00, i_cfg.run_bits} + {2'b00, i_cfg.part_bits}
                      + {2'b00, i_cfg.seq_bits};
    assign pid_pos    = (i_cfg.mode == MODE_PART_LOW) ? {1'b0, i_cfg.run_bits}
                      : ({1'b0, i_cfg.run_bits} + {1'b0, i_cfg.seq_bits});
    assign seq_pos    = (i_cfg.mode == MODE_PART_LOW)
                      ? ({1'b0, i_cfg.run_bits} + {1'b0, i_cfg.part_bits})
                      : {1'b0, i_cfg.run_bits};
    assign pid_masked = SEED_W'(i_cfg.partition_id) & low_mask64(i_cfg.part_bits);
    assign init_base  = (i_cfg.global_seed & low_mask64(i_cfg.run_bits))
                      | shl64(pid_masked, pid_pos);
    assign mask_one   = {{CW{1'b0}}, 1'b1} << i_cfg.seq_bits;
    assign init_mask  = (i_cfg.seq_bits >= BITS_W'(CW)) ? '1
                      : (mask_one[CW-1:0] - {{(CW-1){1'b0}}, 1'b1});

    // New sequence: next id, wrapped to the field
    assign seq_next = (r_seq_cnt + {{(CW-1){1'b0}}, 1'b1}) & r_seq_mask;

    // Draw: 64-bit product from three 32x32 partial products; the high-high
    // term falls outside the modulus
    assign seed_lo   = r_cur_seed[HALF_W-1:0];
    assign seed_hi   = r_cur_seed[SEED_W-1:HALF_W];
    assign prod_ll   = SEED_W'(seed_lo) * SEED_W'(LCG_MULT_LO);
    assign prod_lh   = seed_lo * LCG_MULT_HI;
    assign prod_hl   = seed_hi * LCG_MULT_LO;
    assign draw_seed = prod_ll + {prod_lh + prod_hl, {HALF_W{1'b0}}} + 64'd1;

    always_comb begin
        n_cur_seed  = r_cur_seed;
        n_base_seed = r_base_seed;
        n_seq_cnt   = r_seq_cnt;
        n_seq_mask  = r_seq_mask;
        n_seq_shift = r_seq_shift;
        n_init      = r_init;
        status      = ST_OK;
        frac        = '0;
        case (i_item.op)
            OP_INIT: begin
                if (r_init) begin
                    status = ST_REINIT;
                end else if (i_cfg.mode != MODE_PART_LOW && i_cfg.mode != MODE_SEQ_LOW) begin
                    status = ST_BAD_MODE;
                end else if (i_cfg.run_bits < MIN_RUN_BITS) begin
                    status = ST_RUN_SHORT;
                end else if (i_cfg.seq_bits > BITS_W'(CW)) begin
                    status = ST_SEQ_WIDE;
                end else if (bits_sum > 9'd64) begin
                    status = ST_SUM_WIDE;
                end else begin
                    n_base_seed = init_base;
                    n_cur_seed  = init_base;
                    n_seq_cnt   = '0;
                    n_seq_mask  = init_mask;
                    n_seq_shift = seq_pos[BITS_W-1:0];
                    n_init      = 1'b1;
                end
            end
            OP_NEW_SEQ: begin
                if (!r_init) begin
                    status = ST_UNINIT;
                end else if (seq_next == '0) begin
                    status = ST_EXHAUSTED;
                end else begin
                    n_seq_cnt  = seq_next;
                    n_cur_seed = r_base_seed
                               | shl64(SEED_W'(seq_next), {1'b0, r_seq_shift});
                end
            end
            OP_DRAW: begin
                n_cur_seed = draw_seed;
                frac       = draw_seed[SEED_W-1:FRAC_LSB];
            end
            OP_LOAD: begin
                n_cur_seed = i_item.seed_value;
            end
            default: begin
                n_cur_seed = r_cur_seed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_seed  <= '0;
            r_base_seed <= '0;
            r_seq_cnt   <= '0;
            r_seq_mask  <= '0;
            r_seq_shift <= '0;
            r_init      <= 1'b0;
        end else if (i_advance) begin
            r_cur_seed  <= n_cur_seed;
            r_base_seed <= n_base_seed;
            r_seq_cnt   <= n_seq_cnt;
            r_seq_mask  <= n_seq_mask;
            r_seq_shift <= n_seq_shift;
            r_init      <= n_init;
        end
    end

    assign o_result.status          = status;
    assign o_result.seed_out        = n_cur_seed;
    assign o_result.sequence_id     = SEQ_ID_W'(n_seq_cnt);
    assign o_result.random_fraction = frac;

endmodule

### rtl/core/plsg_out_reg.sv
// ----------------------------------------------------------------------------
// plsg_out_reg
// Result register: holds a finished result word until the sink takes it.
// ----------------------------------------------------------------------------
module plsg_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  plsg_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output plsg_pkg::t_result o_result
);
    import plsg_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/core/parallel_lcg_stream_generator_core.sv
// ----------------------------------------------------------------------------
// parallel_lcg_stream_generator_core
// 64-bit LCG split into independent sequences by partition and sequence id.
//
//   Port    Dir  Content
//   i_in    in   op, seed_value
//   o_out   out  status, seed_out, sequence_id, random_fraction
//   i_cfg   in   register index, write data (always ready)
//
// One word per cycle while o_out.ready is high; a word goes through the input
// and result registers. The step unit's constant multiply-add sets cycle time.
// Reset is synchronous: clears generator state, loads register defaults.
// A stalled sink holds the result register, then the input register fills
// and i_in.ready drops.
// ----------------------------------------------------------------------------
module parallel_lcg_stream_generator_core #(
    parameter int unsigned SEQ_BITS_MAX = plsg_pkg::SEQ_BITS_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plsg_in_if.sink   i_in,
    plsg_out_if.source o_out,
    plsg_cfg_if.sink  i_cfg
);
    import plsg_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   stage_item;
    t_result step_result;
    t_result out_result;
    logic    stage_valid;
    logic    out_valid;
    logic    advance;

    assign i_cfg.ready = 1'b1;

    plsg_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_idx  (i_cfg.index),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    assign in_item.op         = t_op'(i_in.op);
    assign in_item.seed_value = i_in.seed_value;

    // Step when a word is held and the result register is free or draining
    assign advance = stage_valid && (!out_valid || o_out.ready);

    plsg_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .o_ready   (i_in.ready),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    plsg_lcg_unit #(
        .SEQ_BITS_MAX (SEQ_BITS_MAX)
    ) u_lcg_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_result  (step_result)
    );

    plsg_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .i_ready  (o_out.ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid           = out_valid;
    assign o_out.status          = out_result.status;
    assign o_out.seed_out        = out_result.seed_out;
    assign o_out.sequence_id     = out_result.sequence_id;
    assign o_out.random_fraction = out_result.random_fraction;

endmodule

### rtl/core/plsg_checker.sv
// ----------------------------------------------------------------------------
// plsg_checker
// Port-level checks on the result channel of the stream generator.
// ----------------------------------------------------------------------------
module plsg_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [plsg_pkg::STATUS_W-1:0] i_status,
    input logic [plsg_pkg::SEED_W-1:0]   i_seed_out,
    input logic [plsg_pkg::SEQ_ID_W-1:0] i_sequence_id,
    input logic [plsg_pkg::FRAC_W-1:0]   i_random_fraction
);
    import plsg_pkg::*;

    // No result word straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_seed_out)
            && $stable(i_status) && $stable(i_random_fraction))
        else $error("stalled result changed");

    // A fraction is either empty or the top bits of the new seed
    a_frac_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_random_fraction == '0
            || i_random_fraction == i_seed_out[SEED_W-1:FRAC_LSB])
        else $error("fraction does not match seed");

    // Failed operations give no fraction
    a_err_no_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_random_fraction == '0)
        else $error("fraction on failed operation");

    // Before init the sequence id stays at zero
    a_uninit_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_UNINIT |-> i_sequence_id == '0)
        else $error("sequence id set while uninitialised");

endmodule

bind parallel_lcg_stream_generator_core plsg_checker u_plsg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_status          (o_out.status),
    .i_seed_out        (o_out.seed_out),
    .i_sequence_id     (o_out.sequence_id),
    .i_random_fraction (o_out.random_fraction)
);
